// File: sv/gpe_pkg.sv
package gpe_pkg;

  // Input item kinds carried on in_tuser
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_PLACE = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_LINE_HEIGHT  = 2'd0;
  localparam logic [1:0] CFG_LINE_SPACING = 2'd1;
  localparam int unsigned CFG_IDX_W = 2;

  // Special character codes
  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam logic [7:0] SPACE_CODE   = 8'd32;

  // Input tdata: char_code then nine 16-bit fields
  localparam int unsigned IN_DATA_W = 152;

  // One glyph table entry, last field in the lowest bits
  typedef struct packed {
    logic signed [15:0] advance;
    logic signed [15:0] offset_y;
    logic signed [15:0] offset_x;
    logic        [15:0] height;
    logic        [15:0] width;
    logic        [15:0] atlas_y;
    logic        [15:0] atlas_x;
  } gpe_entry_t;

  // Work handed from the lookup stage to the pen stage
  typedef struct packed {
    logic               start;
    logic               newline;
    logic               emit;
    logic signed [15:0] origin_x;
    logic signed [15:0] origin_y;
  } gpe_s1_t;

endpackage

// File: sv/gpe_glyph_table.sv
module gpe_glyph_table #(
  parameter int unsigned GLYPH_COUNT = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  logic [7:0]         wr_code,
  input  gpe_pkg::gpe_entry_t wr_entry,
  input  logic               rd_en,
  input  logic [7:0]         rd_code,
  output gpe_pkg::gpe_entry_t rd_entry
);
  import gpe_pkg::*;

  localparam int unsigned IDX_W = $clog2(GLYPH_COUNT);

  gpe_entry_t             mem [GLYPH_COUNT];
  logic [GLYPH_COUNT-1:0] loaded_r;
  logic [GLYPH_COUNT-1:0] loaded_nxt;
  gpe_entry_t             rd_data_r;
  logic                   rd_zero_r;

  logic             wr_in_range;
  logic             rd_in_range;
  logic [IDX_W-1:0] wr_idx;
  logic [IDX_W-1:0] rd_idx;
  logic [IDX_W-1:0] space_idx;
  logic [IDX_W-1:0] rd_addr;
  logic             rd_zero;

  assign wr_in_range = {1'b0, wr_code} < 9'(GLYPH_COUNT);
  assign rd_in_range = {1'b0, rd_code} < 9'(GLYPH_COUNT);
  assign wr_idx      = wr_code[IDX_W-1:0];
  assign rd_idx      = rd_code[IDX_W-1:0];
  assign space_idx   = SPACE_CODE[IDX_W-1:0];

  // Pick the code's own entry when loaded, else fall back to space
  always_comb begin
    if (rd_in_range && loaded_r[rd_idx]) begin
      rd_addr = rd_idx;
      rd_zero = 1'b0;
    end else begin
      rd_addr = space_idx;
      rd_zero = !loaded_r[space_idx];
    end
  end

  // Set the valid bit of each written entry
  always_comb begin
    loaded_nxt = loaded_r;
    if (wr_en && wr_in_range) begin
      loaded_nxt[wr_idx] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loaded_r <= '0;
    end else begin
      loaded_r <= loaded_nxt;
    end
  end

  // Table storage: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en && wr_in_range) begin
      mem[wr_idx] <= wr_entry;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
      rd_zero_r <= rd_zero;
    end
  end

  // A code that falls back to an unloaded space entry reads as zero
  assign rd_entry = rd_zero_r ? '0 : rd_data_r;

  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && wr_in_range) |=> loaded_r[$past(wr_idx)])
    else $error("glyph valid bit not set after load");

endmodule

// File: sv/gpe_pen_unit.sv
module gpe_pen_unit #(
  parameter int unsigned COORD_BITS = 20,
  parameter int unsigned OUT_W      = 104
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr,
  input  logic [gpe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                   cfg_data,
  input  logic                          fire,
  input  gpe_pkg::gpe_s1_t              s1,
  input  gpe_pkg::gpe_entry_t           entry,
  output logic                          slot_free,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [OUT_W-1:0]              out_tdata
);
  import gpe_pkg::*;

  localparam int unsigned SW = COORD_BITS + 2;
  localparam logic signed [SW-1:0] C_MAX = SW'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
  localparam logic signed [SW-1:0] C_MIN = -C_MAX - SW'(1);

  typedef logic signed [COORD_BITS-1:0] coord_t;

  function automatic coord_t sat(input logic signed [SW-1:0] v);
    coord_t r;
    if (v > C_MAX) begin
      r = C_MAX[COORD_BITS-1:0];
    end else if (v < C_MIN) begin
      r = C_MIN[COORD_BITS-1:0];
    end else begin
      r = v[COORD_BITS-1:0];
    end
    return r;
  endfunction

  logic        [15:0] line_height_r;
  logic signed [15:0] line_spacing_r;

  coord_t pen_x_r, pen_x_nxt;
  coord_t pen_y_r, pen_y_nxt;
  coord_t line_start_r, line_start_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0] out_data_r;

  coord_t dest_x;
  coord_t dest_y;
  coord_t adv_x;
  coord_t nl_y;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_height_r  <= '0;
      line_spacing_r <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        CFG_LINE_HEIGHT:  line_height_r  <= cfg_data;
        CFG_LINE_SPACING: line_spacing_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Destination, pen advance and newline step, each a sum saturated once
  assign dest_x = sat(SW'(pen_x_r) + SW'(entry.offset_x));
  assign dest_y = sat(SW'(pen_y_r) + SW'(entry.offset_y));
  assign adv_x  = sat(SW'(pen_x_r) + SW'(entry.advance));
  assign nl_y   = sat(SW'(pen_y_r) + signed'(SW'(line_height_r)) + SW'(line_spacing_r));

  assign slot_free = !out_valid_r || out_tready;

  // Advance the pen on each item leaving the lookup stage
  always_comb begin
    pen_x_nxt      = pen_x_r;
    pen_y_nxt      = pen_y_r;
    line_start_nxt = line_start_r;
    if (fire) begin
      priority if (s1.start) begin
        pen_x_nxt      = COORD_BITS'(s1.origin_x);
        pen_y_nxt      = COORD_BITS'(s1.origin_y);
        line_start_nxt = COORD_BITS'(s1.origin_x);
      end else if (s1.newline) begin
        pen_x_nxt = line_start_r;
        pen_y_nxt = nl_y;
      end else if (s1.emit) begin
        pen_x_nxt = adv_x;
      end
    end
  end

  // Output register: load on a placed glyph, drop on transfer
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire && s1.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pen_x_r      <= '0;
      pen_y_r      <= '0;
      line_start_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      pen_x_r      <= pen_x_nxt;
      pen_y_r      <= pen_y_nxt;
      line_start_r <= line_start_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && s1.emit) begin
      out_data_r <= OUT_W'({dest_y, dest_x, entry.height, entry.width,
                            entry.atlas_y, entry.atlas_x});
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && s1.emit) |-> (!out_valid_r || out_tready))
    else $error("pending result overwritten");

  a_newline_home: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && s1.newline && !s1.start) |=> (pen_x_r == line_start_r))
    else $error("pen x not at line start after newline");

endmodule

// File: sv/glyph_placement_engine.sv
// Glyph placement engine: lays out bitmap-font glyphs for a blitter.
// Input stream (in_*): one item per transfer; in_tuser selects load glyph
// entry, start string at origin, or place character. Loads fill the glyph
// table, start items set the pen, place items with the newline code move
// the pen to the next line, any other placed code yields one result.
// Result stream (out_*): source rectangle in the atlas and saturated
// destination point, one per placed non-newline character.
// Configuration (cfg_*): line height and line spacing, always ready;
// write them only while the block is idle.
// A result passes the lookup stage register and then the output register.
// Throughput: one item per cycle unless a blocked result stalls the input,
// set by the single read port of the glyph table and the pen update after it.
// Reset clears the pen, the configuration and all table valid bits at once;
// unloaded codes fall back to the space entry, or to zeros if space is
// unloaded. No clearing pass is needed, items are taken right after reset.
// When the receiver stalls, one result waits in the output register while
// the next item is still looked up; further input waits only behind a
// second result.
module glyph_placement_engine #(
  parameter int unsigned GLYPH_COUNT = 256,
  parameter int unsigned COORD_BITS  = 20
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // char_code, atlas_x, atlas_y, glyph_width, glyph_height,
  // offset_x, offset_y, advance, origin_x, origin_y
  input  logic [gpe_pkg::IN_DATA_W-1:0]  in_tdata,
  // opcode
  input  logic [1:0]                     in_tuser,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // src_x, src_y, src_width, src_height, dest_x, dest_y, zero fill
  output logic [((64 + 2 * COORD_BITS + 7) / 8) * 8 - 1:0] out_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [gpe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [15:0]                    cfg_data
);
  import gpe_pkg::*;

  localparam int unsigned OUT_W = ((64 + 2 * COORD_BITS + 7) / 8) * 8;

  logic       in_fire;
  logic [1:0] op;
  logic [7:0] code;
  gpe_entry_t wr_entry;
  gpe_entry_t rd_entry;

  logic    s1_valid_r, s1_valid_nxt;
  gpe_s1_t s1_r, s1_nxt;
  logic    s1_adv;
  logic    slot_free;

  assign op        = in_tuser;
  assign code      = in_tdata[7:0];
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign wr_entry.atlas_x  = in_tdata[23:8];
  assign wr_entry.atlas_y  = in_tdata[39:24];
  assign wr_entry.width    = in_tdata[55:40];
  assign wr_entry.height   = in_tdata[71:56];
  assign wr_entry.offset_x = in_tdata[87:72];
  assign wr_entry.offset_y = in_tdata[103:88];
  assign wr_entry.advance  = in_tdata[119:104];

  // Lookup stage holds while its result cannot enter the output register
  assign s1_adv    = s1_valid_r && (!s1_r.emit || slot_free);
  assign in_tready = !s1_valid_r || s1_adv;

  always_comb begin
    s1_nxt          = s1_r;
    s1_nxt.start    = (op == OP_START);
    s1_nxt.newline  = (op == OP_PLACE) && (code == NEWLINE_CODE);
    s1_nxt.emit     = (op == OP_PLACE) && (code != NEWLINE_CODE);
    s1_nxt.origin_x = in_tdata[135:120];
    s1_nxt.origin_y = in_tdata[151:136];
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = (op == OP_START) || (op == OP_PLACE);
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_r <= s1_nxt;
    end
  end

  gpe_glyph_table #(
    .GLYPH_COUNT (GLYPH_COUNT)
  ) u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (in_fire && (op == OP_LOAD)),
    .wr_code  (code),
    .wr_entry (wr_entry),
    .rd_en    (in_fire && (op == OP_PLACE)),
    .rd_code  (code),
    .rd_entry (rd_entry)
  );

  gpe_pen_unit #(
    .COORD_BITS (COORD_BITS),
    .OUT_W      (OUT_W)
  ) u_pen (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fire       (s1_adv),
    .s1         (s1_r),
    .entry      (rd_entry),
    .slot_free  (slot_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  a_stall_only_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_valid_r && s1_r.emit && out_tvalid && !out_tready))
    else $error("input stalled without a blocked result");

  a_stage_keeps_item: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> (s1_valid_r && $stable(s1_r)))
    else $error("lookup stage lost a stalled item");

endmodule

// File: tb/sv/tb_glyph_placement_engine.sv
module tb_glyph_placement_engine;
  timeunit 1ns;
  timeprecision 1ps;

  import gpe_pkg::*;

  localparam int COORD_MAX = (1 << 19) - 1;
  localparam int COORD_MIN = -(1 << 19);

  // One placed glyph as it leaves on out_tdata, last field in the lowest bits
  typedef struct packed {
    logic signed [19:0] dest_y;
    logic signed [19:0] dest_x;
    logic        [15:0] src_height;
    logic        [15:0] src_width;
    logic        [15:0] src_y;
    logic        [15:0] src_x;
  } placement_t;

  // Glyph table and pen model plus the queue of placements still owed by the block
  class glyph_layout_board;
    gpe_entry_t         glyph_tab [256];
    bit                 glyph_valid [256];
    int                 pen_x;
    int                 pen_y;
    int                 line_x;
    logic        [15:0] line_height;
    logic signed [15:0] line_spacing;
    placement_t         placements_q [$];
    int                 errors;

    function new();
      foreach (glyph_tab[i]) begin
        glyph_tab[i]   = '0;
        glyph_valid[i] = 1'b0;
      end
      pen_x        = 0;
      pen_y        = 0;
      line_x       = 0;
      line_height  = '0;
      line_spacing = '0;
      errors       = 0;
    endfunction

    function int clamp_coord(int v);
      if (v > COORD_MAX) return COORD_MAX;
      if (v < COORD_MIN) return COORD_MIN;
      return v;
    endfunction

    function int pending();
      return placements_q.size();
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
      case (idx)
        CFG_LINE_HEIGHT:  line_height = val;
        CFG_LINE_SPACING: line_spacing = val;
        default: ;
      endcase
    endfunction

    // Advance the model by one accepted item, queue the placement it causes
    function void note_item(logic [1:0] op, logic [IN_DATA_W-1:0] d);
      logic [7:0] code;
      gpe_entry_t e;
      placement_t p;
      code = d[7:0];
      case (op)
        OP_LOAD: begin
          glyph_tab[code]   = gpe_entry_t'(d[119:8]);
          glyph_valid[code] = 1'b1;
        end
        OP_START: begin
          pen_x  = clamp_coord($signed(d[135:120]));
          pen_y  = clamp_coord($signed(d[151:136]));
          line_x = pen_x;
        end
        OP_PLACE: begin
          if (code == NEWLINE_CODE) begin
            pen_x = line_x;
            pen_y = clamp_coord(pen_y + int'(line_height) + int'(line_spacing));
          end else begin
            // unloaded codes borrow the space entry, zero if space is unloaded too
            e = glyph_valid[code] ? glyph_tab[code] : glyph_tab[SPACE_CODE];
            p.src_x      = e.atlas_x;
            p.src_y      = e.atlas_y;
            p.src_width  = e.width;
            p.src_height = e.height;
            p.dest_x     = 20'(clamp_coord(pen_x + int'(e.offset_x)));
            p.dest_y     = 20'(clamp_coord(pen_y + int'(e.offset_y)));
            placements_q.push_back(p);
            pen_x = clamp_coord(pen_x + int'(e.advance));
          end
        end
        default: ;
      endcase
    endfunction

    function void field_cmp(string name, int want, int got, longint stamp);
      if (want != got) begin
        $display("%0d ns: %s mismatch, expected %0d, actual %0d", stamp, name, want, got);
        errors++;
      end
    endfunction

    // Compare one result transfer with the oldest queued placement
    function void check_result(logic [103:0] raw, longint stamp);
      placement_t want;
      placement_t got;
      got = placement_t'(raw);
      if (placements_q.size() == 0) begin
        $display("%0d ns: result with nothing expected, expected none, actual %h",
                 stamp, raw);
        errors++;
        return;
      end
      want = placements_q.pop_front();
      field_cmp("src_x", want.src_x, got.src_x, stamp);
      field_cmp("src_y", want.src_y, got.src_y, stamp);
      field_cmp("src_width", want.src_width, got.src_width, stamp);
      field_cmp("src_height", want.src_height, got.src_height, stamp);
      field_cmp("dest_x", want.dest_x, got.dest_x, stamp);
      field_cmp("dest_y", want.dest_y, got.dest_y, stamp);
    endfunction
  endclass

  localparam logic [1:0]           OP_SPARE     = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE    = 2'd3;
  localparam int                   DRAIN_CYCLES = 4;
  localparam int                   LONG_HOLD    = 400;
  localparam int                   QUIET_LIMIT  = 4000;
  localparam int                   PHASE_ITEMS  = 360;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [1:0]            in_tuser = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [103:0]          out_tdata;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [15:0]           cfg_data = '0;

  glyph_layout_board board = new();
  int                items_in = 0;
  int                quiet = 0;
  bit                tx_calm = 1'b0;
  logic [7:0]        font [12];

  glyph_placement_engine i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Track every transfer on the three channels
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) board.check_result(out_tdata, $time);
      if (cfg_valid && cfg_ready) board.set_reg(cfg_index, cfg_data);
      if (in_tvalid && in_tready) begin
        board.note_item(in_tuser, in_tdata);
        items_in++;
      end
    end
  end

  // Stop a hung run: count cycles without any transfer
  always @(posedge clk) begin
    if (rst_n && ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
                  (cfg_valid && cfg_ready))) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet == QUIET_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Mostly short gaps, a few long ones, none while calm
  function automatic int pick_gap(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [15:0] pick_field();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hffff;
      2: return 16'h7fff;
      3: return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [IN_DATA_W-1:0] rand_bits();
    logic [159:0] w;
    w = {$urandom, $urandom, $urandom, $urandom, $urandom};
    return w[IN_DATA_W-1:0];
  endfunction

  function automatic gpe_entry_t random_entry();
    gpe_entry_t e;
    e.atlas_x  = pick_field();
    e.atlas_y  = pick_field();
    e.width    = pick_field();
    e.height   = pick_field();
    e.offset_x = pick_field();
    e.offset_y = pick_field();
    e.advance  = pick_field();
    return e;
  endfunction

  // Mostly codes of the working font, sometimes any code
  function automatic logic [7:0] font_code();
    if ($urandom_range(0, 9) < 7) return font[$urandom_range(0, 11)];
    return 8'($urandom_range(0, 255));
  endfunction

  // Offer one item and hold it until the transfer
  task automatic send_item(input logic [1:0] op, input logic [IN_DATA_W-1:0] d);
    int gap;
    if ($urandom_range(0, 63) == 0) tx_calm = !tx_calm;
    gap = pick_gap(tx_calm);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tuser  <= op;
    in_tdata  <= d;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic send_entry(input logic [7:0] code, input gpe_entry_t e);
    logic [IN_DATA_W-1:0] d;
    d = rand_bits();
    d[7:0]   = code;
    d[119:8] = e;
    send_item(OP_LOAD, d);
  endtask

  task automatic send_start(input logic [15:0] ox, input logic [15:0] oy);
    logic [IN_DATA_W-1:0] d;
    d = rand_bits();
    d[135:120] = ox;
    d[151:136] = oy;
    send_item(OP_START, d);
  endtask

  task automatic send_place(input logic [7:0] code);
    logic [IN_DATA_W-1:0] d;
    d = rand_bits();
    d[7:0] = code;
    send_item(OP_PLACE, d);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Stop offering, wait for every owed result, let items without results retire
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_directed();
    gpe_entry_t e;
    send_place(8'd65);
    send_place(NEWLINE_CODE);
    send_item(OP_SPARE, rand_bits());
    send_entry(SPACE_CODE, random_entry());
    send_place(8'd200);
    e.atlas_x  = 16'hffff;
    e.atlas_y  = 16'hffff;
    e.width    = 16'hffff;
    e.height   = 16'hffff;
    e.offset_x = 16'sh7fff;
    e.offset_y = 16'sh7fff;
    e.advance  = 16'sh7fff;
    send_entry(8'd255, e);
    e = '0;
    e.offset_x = 16'sh8000;
    e.offset_y = 16'sh8000;
    e.advance  = 16'sh8000;
    send_entry(8'd0, e);
    // a loaded newline entry still only moves the pen
    send_entry(NEWLINE_CODE, random_entry());
    send_place(NEWLINE_CODE);
    // drive the pen into the upper bound
    send_start(16'h7fff, 16'h7fff);
    repeat (6) send_place(NEWLINE_CODE);
    send_place(8'd255);
    send_place(8'd0);
    send_start(16'h8000, 16'h8000);
    send_place(8'd0);
    send_place(8'd255);
    send_place(8'd128);
  endtask

  // Mostly lines of text after a start, with table loads and noise mixed in
  task automatic run_random(input int budget);
    int         sent;
    int         r;
    int         n;
    bit         same_code;
    logic [7:0] rep;
    logic [1:0] op;
    sent = 0;
    while (sent < budget) begin
      r = $urandom_range(0, 99);
      if (r < 15) begin
        n = $urandom_range(1, 6);
        repeat (n) begin
          send_entry(font_code(), random_entry());
          sent++;
        end
      end else if (r < 22) begin
        op = 2'($urandom_range(0, 3));
        send_item(op, rand_bits());
        if (op != OP_SPARE) sent++;
      end else begin
        send_start(pick_field(), pick_field());
        sent++;
        n = $urandom_range(1, 40);
        same_code = ($urandom_range(0, 3) == 0);
        rep = font_code();
        repeat (n) begin
          r = $urandom_range(0, 99);
          if (same_code) send_place(rep);
          else if (r < 10) send_place(NEWLINE_CODE);
          else if (r < 25) send_place(8'($urandom_range(0, 255)));
          else send_place(font_code());
          sent++;
        end
      end
    end
  endtask

  // Receiver: random stalls, one long hold-off once the block has taken enough input
  initial begin : receiver
    int stall;
    bit held;
    bit rx_calm;
    held = 1'b0;
    rx_calm = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held && items_in >= 700) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        if ($urandom_range(0, 31) == 0) rx_calm = !rx_calm;
        stall = pick_gap(rx_calm);
        if (stall > 0) begin
          out_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    font[0] = SPACE_CODE;
    font[1] = NEWLINE_CODE;
    font[2] = 8'd0;
    font[3] = 8'd255;
    for (int k = 4; k < 12; k++) font[k] = 8'($urandom_range(0, 255));
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int phase = 0; phase < 5; phase++) begin
      drain();
      case (phase)
        0: begin
          write_reg(CFG_LINE_HEIGHT, 16'hffff);
          write_reg(CFG_LINE_SPACING, 16'h7fff);
        end
        1: begin
          write_reg(CFG_LINE_HEIGHT, 16'h0000);
          write_reg(CFG_LINE_SPACING, 16'h8000);
        end
        2: begin
          write_reg(CFG_LINE_HEIGHT, 16'($urandom));
          write_reg(CFG_LINE_SPACING, 16'($urandom));
          write_reg(CFG_SPARE, 16'($urandom));
        end
        3: begin
          write_reg(CFG_LINE_HEIGHT, 16'hffff);
          write_reg(CFG_LINE_SPACING, 16'h8000);
        end
        default: begin
          write_reg(CFG_LINE_HEIGHT, 16'($urandom_range(0, 64)));
          write_reg(CFG_LINE_SPACING, 16'($urandom));
        end
      endcase
      if (phase == 0) run_directed();
      run_random(PHASE_ITEMS);
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
